/* rtl/core/http2_settings_parser_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the SETTINGS payload parser.
// ----------------------------------------------------------------------------
`ifndef HTTP2_SETTINGS_PARSER_ASSERT_SVH
`define HTTP2_SETTINGS_PARSER_ASSERT_SVH

// Concurrent assertion that is switched off while reset is high.
`define H2SP_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that also holds across reset.
`define H2SP_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/h2sp_pkg.sv */
// ----------------------------------------------------------------------------
// h2sp_pkg
// Types and constants shared by the SETTINGS payload parser.
// ----------------------------------------------------------------------------
`default_nettype none

package h2sp_pkg;

  // One input item: a payload byte or an empty-payload marker.
  typedef struct packed {
    logic       mode;
    logic [7:0] payload_byte;
    logic       last_byte;
  } in_item_t;

  // One result item: status and the committed settings.
  typedef struct packed {
    logic        status;
    logic [31:0] table_size;
    logic        push_enabled;
    logic [31:0] max_streams;
    logic [31:0] window_size;
    logic [31:0] frame_size;
    logic [31:0] header_list_size;
  } out_item_t;

  // A full set of settings, working or committed.
  typedef struct packed {
    logic [31:0] table_size;
    logic        push_enabled;
    logic [31:0] max_streams;
    logic [31:0] window_size;
    logic [31:0] frame_size;
    logic [31:0] header_list_size;
  } settings_t;

  // What one step of the parser hands to the top level.
  typedef struct packed {
    logic emit;
    logic status;
    logic commit;
  } step_res_t;

  // Input modes.
  localparam logic MODE_BYTE  = 1'b0;
  localparam logic MODE_EMPTY = 1'b1;

  // Result status codes.
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_BAD_LEN = 1'b1;

  // Byte position inside a six-byte entry.
  localparam logic [2:0] PH_ID_HI  = 3'd0;
  localparam logic [2:0] PH_ID_LO  = 3'd1;
  localparam logic [2:0] PH_VAL_B3 = 3'd2;
  localparam logic [2:0] PH_VAL_B2 = 3'd3;
  localparam logic [2:0] PH_VAL_B1 = 3'd4;
  localparam logic [2:0] PH_VAL_B0 = 3'd5;

  // Setting identifiers.
  localparam logic [15:0] ID_TABLE_SIZE  = 16'd1;
  localparam logic [15:0] ID_ENABLE_PUSH = 16'd2;
  localparam logic [15:0] ID_MAX_STREAMS = 16'd3;
  localparam logic [15:0] ID_WINDOW_SIZE = 16'd4;
  localparam logic [15:0] ID_FRAME_SIZE  = 16'd5;
  localparam logic [15:0] ID_LIST_SIZE   = 16'd6;

  // Configuration register indexes.
  localparam logic [1:0] CFG_TABLE_SIZE  = 2'd0;
  localparam logic [1:0] CFG_MAX_STREAMS = 2'd1;
  localparam logic [1:0] CFG_WINDOW_SIZE = 2'd2;
  localparam logic [1:0] CFG_FRAME_SIZE  = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [31:0] RST_TABLE_SIZE  = 32'd4096;
  localparam logic [31:0] RST_MAX_STREAMS = 32'd100;
  localparam logic [31:0] RST_WINDOW_SIZE = 32'd65535;
  localparam logic [31:0] RST_FRAME_SIZE  = 32'd16384;

  // Default header list size: unlimited.
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  // Committed copy after reset: the register reset values.
  localparam settings_t KEPT_RST = '{
    table_size:       RST_TABLE_SIZE,
    push_enabled:     1'b1,
    max_streams:      RST_MAX_STREAMS,
    window_size:      RST_WINDOW_SIZE,
    frame_size:       RST_FRAME_SIZE,
    header_list_size: ALL_ONES
  };

  // Working copy after reset: cleared, with push enabled.
  localparam settings_t WORK_RST = '{
    table_size:       32'd0,
    push_enabled:     1'b1,
    max_streams:      32'd0,
    window_size:      32'd0,
    frame_size:       32'd0,
    header_list_size: 32'd0
  };

endpackage

`default_nettype wire

/* rtl/core/h2sp_core.sv */
// ----------------------------------------------------------------------------
// h2sp_core
// Entry assembly and working copy of the settings; one item per step.
// ----------------------------------------------------------------------------
`default_nettype none

module h2sp_core
  import h2sp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      step,
  input  wire in_item_t  item,
  input  wire settings_t dflt,
  output step_res_t      res,
  output settings_t      commit_set
);

  logic [2:0]  phase;
  logic [2:0]  phase_next;
  logic        in_payload;
  logic        in_payload_next;
  logic [15:0] ident;
  logic [15:0] ident_next;
  logic [23:0] value;
  logic [23:0] value_next;
  settings_t   work;
  settings_t   work_next;
  logic [2:0]  cur_phase;
  logic [31:0] word;

  // Next state of the entry assembler and the working copy.
  always_comb begin
    phase_next      = phase;
    in_payload_next = in_payload;
    ident_next      = ident;
    value_next      = value;
    work_next       = work;
    res             = '0;
    commit_set      = dflt;
    // A new payload starts from the defaults at its first byte.
    cur_phase       = in_payload ? phase : PH_ID_HI;
    word            = {value, item.payload_byte};

    if (item.mode == MODE_EMPTY) begin
      // Empty payload: drop any partial payload and commit the defaults.
      phase_next      = PH_ID_HI;
      in_payload_next = 1'b0;
      ident_next      = '0;
      value_next      = '0;
      res.emit        = 1'b1;
      res.status      = STATUS_OK;
      res.commit      = 1'b1;
      commit_set      = dflt;
    end else begin
      if (!in_payload) begin
        work_next = dflt;
      end
      in_payload_next = 1'b1;

      unique case (cur_phase)
        PH_ID_LO: begin
          ident_next = {ident[15:8], item.payload_byte};
          phase_next = PH_VAL_B3;
        end
        PH_VAL_B3, PH_VAL_B2, PH_VAL_B1: begin
          value_next = {value[15:0], item.payload_byte};
          phase_next = cur_phase + 3'd1;
        end
        PH_VAL_B0: begin
          // The entry is complete: update its setting, ignore unknown ones.
          case (ident)
            ID_TABLE_SIZE:  work_next.table_size       = word;
            ID_ENABLE_PUSH: work_next.push_enabled     = |word;
            ID_MAX_STREAMS: work_next.max_streams      = word;
            ID_WINDOW_SIZE: work_next.window_size      = word;
            ID_FRAME_SIZE:  work_next.frame_size       = word;
            ID_LIST_SIZE:   work_next.header_list_size = word;
            default: ;
          endcase
          value_next = '0;
          phase_next = PH_ID_HI;
        end
        default: begin
          ident_next = {item.payload_byte, 8'h00};
          value_next = '0;
          phase_next = PH_ID_LO;
        end
      endcase

      // Last byte: commit only if the payload ended on an entry boundary.
      if (item.last_byte) begin
        res.emit        = 1'b1;
        res.status      = (phase_next != PH_ID_HI) ? STATUS_BAD_LEN : STATUS_OK;
        res.commit      = (phase_next == PH_ID_HI);
        commit_set      = work_next;
        in_payload_next = 1'b0;
        phase_next      = PH_ID_HI;
        ident_next      = '0;
        value_next      = '0;
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_ID_HI;
      in_payload <= 1'b0;
      ident      <= '0;
      value      <= '0;
      work       <= WORK_RST;
    end else if (step) begin
      phase      <= phase_next;
      in_payload <= in_payload_next;
      ident      <= ident_next;
      value      <= value_next;
      work       <= work_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/http2_settings_parser.sv */
// ----------------------------------------------------------------------------
// http2_settings_parser
// Byte-serial SETTINGS payload parser with committed settings output.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle for any payload while the output
// register is not stalled. An accepted item is held in an input register and
// processed once the output register is free or being emptied; its result is
// then loaded into the output register. Results come only on a last byte or
// an empty-payload item and always carry the committed settings. The default
// registers may be written only while the block is idle; a write takes effect
// at the start of the next payload.
`default_nettype none

module http2_settings_parser
  import h2sp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_item,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_item,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_idx,
  input  wire logic [31:0] cfg_data
);

  logic [31:0] dflt_table;
  logic [31:0] dflt_streams;
  logic [31:0] dflt_window;
  logic [31:0] dflt_frame;
  settings_t   dflt;
  settings_t   kept;
  settings_t   kept_next;
  settings_t   commit_set;
  step_res_t   res;
  in_item_t    held;
  logic        held_valid;
  logic        advance;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      dflt_table   <= RST_TABLE_SIZE;
      dflt_streams <= RST_MAX_STREAMS;
      dflt_window  <= RST_WINDOW_SIZE;
      dflt_frame   <= RST_FRAME_SIZE;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_TABLE_SIZE:  dflt_table   <= cfg_data;
        CFG_MAX_STREAMS: dflt_streams <= cfg_data;
        CFG_WINDOW_SIZE: dflt_window  <= cfg_data;
        CFG_FRAME_SIZE:  dflt_frame   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Defaults loaded at each payload start.
  always_comb begin
    dflt.table_size       = dflt_table;
    dflt.push_enabled     = 1'b1;
    dflt.max_streams      = dflt_streams;
    dflt.window_size      = dflt_window;
    dflt.frame_size       = dflt_frame;
    dflt.header_list_size = ALL_ONES;
  end

  // The held item moves on when the output register can take a result.
  assign advance  = held_valid && (!out_valid || out_ready);
  assign in_ready = !held_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held <= in_item;
    end
  end

  h2sp_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .item       (held),
    .dflt       (dflt),
    .res        (res),
    .commit_set (commit_set)
  );

  // Committed copy of the settings.
  assign kept_next = res.commit ? commit_set : kept;

  always_ff @(posedge clk) begin
    if (rst) begin
      kept <= KEPT_RST;
    end else if (advance) begin
      kept <= kept_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.emit) begin
      out_item.status           <= res.status;
      out_item.table_size       <= kept_next.table_size;
      out_item.push_enabled     <= kept_next.push_enabled;
      out_item.max_streams      <= kept_next.max_streams;
      out_item.window_size      <= kept_next.window_size;
      out_item.frame_size       <= kept_next.frame_size;
      out_item.header_list_size <= kept_next.header_list_size;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/h2sp_checker.sv */
// ----------------------------------------------------------------------------
// h2sp_checker
// Port-level assertions for the SETTINGS payload parser, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "http2_settings_parser_assert.svh"

module h2sp_checker
  import h2sp_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire out_item_t   out_item
);

  // A stalled result item holds until it is taken.
  `H2SP_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_item), "result item changed while stalled")

  // Reset empties the output register.
  `H2SP_ASSERT_ALWAYS(a_out_reset, clk, rst |=> !out_valid, "result item valid after reset")

  // With the output register empty an item is always taken.
  `H2SP_ASSERT(a_ready_empty, clk, rst, !out_valid |-> in_ready, "input stalled with empty output")

  // A result being taken frees room for the next item in the same cycle.
  `H2SP_ASSERT(a_ready_drain, clk, rst, out_valid && out_ready |-> in_ready, "input stalled while output drains")

endmodule

bind http2_settings_parser h2sp_checker u_h2sp_checker (.*);

`default_nettype wire
